[design/four_channel_dma_controller_top_macros.svh]
// Assertion macros for the four-channel DMA controller
`ifndef FOUR_CHANNEL_DMA_CONTROLLER_TOP_MACROS_SVH
`define FOUR_CHANNEL_DMA_CONTROLLER_TOP_MACROS_SVH

// check a condition-to-consequence implication in the same cycle
`define FCDMA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check a consequence in the cycle after the condition
`define FCDMA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/fcdma_pkg.sv]
// Package: beat types, operation, status, register offset and mode codes
`timescale 1ns / 1ps
package fcdma_pkg;

	localparam int NumCh = 4;

	localparam logic [1:0] OP_IO_READ    = 2'd0;
	localparam logic [1:0] OP_IO_WRITE   = 2'd1;
	localparam logic [1:0] OP_DEV_TO_MEM = 2'd2;
	localparam logic [1:0] OP_MEM_TO_DEV = 2'd3;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
	localparam logic [1:0] ST_INVALID     = 2'd2;
	localparam logic [1:0] ST_MEM_FAULT   = 2'd3;

	localparam logic [3:0] IO_CH_LAST    = 4'd7;
	localparam logic [3:0] IO_STATUS     = 4'd8;
	localparam logic [3:0] IO_REQUEST    = 4'd9;
	localparam logic [3:0] IO_SMASK      = 4'd10;
	localparam logic [3:0] IO_MODE       = 4'd11;
	localparam logic [3:0] IO_CLR_FF     = 4'd12;
	localparam logic [3:0] IO_MCLR_TEMP  = 4'd13;
	localparam logic [3:0] IO_CLR_MASK   = 4'd14;
	localparam logic [3:0] IO_WR_MASK    = 4'd15;

	localparam logic [1:0] XT_VERIFY = 2'd0;
	localparam logic [1:0] XT_WRITE  = 2'd1;
	localparam logic [1:0] XT_READ   = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] io_offset;
		logic [1:0] channel;
		logic [7:0] data;
		logic [3:0] dreq_lines;
		logic       mem_fault;
	} dma_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  read_data;
		logic        mem_valid;
		logic        mem_write;
		logic [23:0] mem_address;
		logic [7:0]  mem_data;
		logic        terminal;
	} dma_result_t;

endpackage

[design/four_channel_dma_controller_top.sv]
// Four-channel DMA controller: register file, transfer sequencing and result register
`timescale 1ns / 1ps
`include "four_channel_dma_controller_top_macros.svh"
// Takes one request beat per clock and returns exactly one result beat for it, in the next
// cycle, from the result register. All register updates for a beat (byte flip-flop, masks,
// requests, terminal-count bits, address and count stepping, auto-init reload) are made at
// the edge that accepts it, so the next beat sees them at once. The only limit on that rate
// is the result register: req_stall rises while a result waits and rsp_stall is high. The
// user must write page registers via the cfg port only while idle; nothing enforces it.
module four_channel_dma_controller_top import fcdma_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  dma_item_t   req_item,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output dma_result_t rsp_item,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0]  page_q      [NumCh];
	logic [15:0] base_addr_q [NumCh];
	logic [15:0] cur_addr_q  [NumCh];
	logic [15:0] base_cnt_q  [NumCh];
	logic [15:0] cur_cnt_q   [NumCh];
	logic [3:0]  mode_q      [NumCh];
	logic        disable_q;
	logic [3:0]  soft_req_q;
	logic [3:0]  tc_q;
	logic [3:0]  mask_q;
	logic [7:0]  temp_q;
	logic        ff_q;
	logic        rsp_valid_q;
	dma_result_t rsp_item_q;

	logic        accept;
	logic [1:0]  idx;
	logic [15:0] ca, cc, ba, bc;
	logic [3:0]  md;
	logic [3:0]  reqs;

	dma_result_t res;
	logic        nxt_disable;
	logic [3:0]  nxt_soft, nxt_tc, nxt_mask;
	logic [7:0]  nxt_temp;
	logic        nxt_ff;
	logic        we_addr, we_cnt, we_xfer, we_mode;
	logic [15:0] new_ba, new_ca, new_bc, new_cc;
	logic [15:0] xf_addr, xf_cnt;

	assign accept    = req_valid && !req_stall;
	assign req_stall = rsp_valid_q && rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

	assign idx  = (req_item.op[1]) ? req_item.channel : req_item.io_offset[2:1];
	assign ca   = cur_addr_q[idx];
	assign cc   = cur_cnt_q[idx];
	assign ba   = base_addr_q[idx];
	assign bc   = base_cnt_q[idx];
	assign md   = mode_q[req_item.channel];
	assign reqs = soft_req_q | req_item.dreq_lines;

	always_comb begin
		logic [3:0] bit_d;
		logic [3:0] bit_c;
		logic [15:0] w;
		logic       to_mem;
		logic       term;
		logic [1:0] want;
		bit_d       = 4'b0001 << req_item.data[1:0];
		bit_c       = 4'b0001 << req_item.channel;
		w           = 16'd0;
		to_mem      = (req_item.op == OP_DEV_TO_MEM);
		want        = to_mem ? XT_WRITE : XT_READ;
		term        = 1'b0;
		res         = '0;
		nxt_disable = disable_q;
		nxt_soft    = soft_req_q;
		nxt_tc      = tc_q;
		nxt_mask    = mask_q;
		nxt_temp    = temp_q;
		nxt_ff      = ff_q;
		we_addr     = 1'b0;
		we_cnt      = 1'b0;
		we_xfer     = 1'b0;
		we_mode     = 1'b0;
		new_ba      = ff_q ? {req_item.data, ba[7:0]} : {ba[15:8], req_item.data};
		new_ca      = ff_q ? {req_item.data, ca[7:0]} : {ca[15:8], req_item.data};
		new_bc      = ff_q ? {req_item.data, bc[7:0]} : {bc[15:8], req_item.data};
		new_cc      = ff_q ? {req_item.data, cc[7:0]} : {cc[15:8], req_item.data};
		xf_addr     = md[3] ? ca - 16'd1 : ca + 16'd1;
		xf_cnt      = cc - 16'd1;
		case (req_item.op)
			OP_IO_READ: begin
				case (req_item.io_offset) inside
					[4'd0:IO_CH_LAST]: begin
						w             = req_item.io_offset[0] ? cc : ca;
						res.read_data = ff_q ? w[15:8] : w[7:0];
						nxt_ff        = !ff_q;
					end
					IO_STATUS: begin
						res.read_data = {reqs, tc_q};
						nxt_tc        = 4'd0;
					end
					IO_MCLR_TEMP: res.read_data = temp_q;
					default: res.status = ST_UNSUPPORTED;
				endcase
			end
			OP_IO_WRITE: begin
				case (req_item.io_offset) inside
					[4'd0:IO_CH_LAST]: begin
						we_cnt  = req_item.io_offset[0];
						we_addr = !req_item.io_offset[0];
						nxt_ff  = !ff_q;
					end
					IO_STATUS: nxt_disable = req_item.data[2];
					IO_REQUEST: nxt_soft = req_item.data[2] ? (soft_req_q | bit_d)
						: (soft_req_q & ~bit_d);
					IO_SMASK: nxt_mask = req_item.data[2] ? (mask_q | bit_d)
						: (mask_q & ~bit_d);
					IO_MODE: we_mode = 1'b1;
					IO_CLR_FF: nxt_ff = 1'b0;
					IO_MCLR_TEMP: begin
						nxt_disable = 1'b0;
						nxt_soft    = 4'd0;
						nxt_tc      = 4'd0;
						nxt_mask    = 4'hf;
						nxt_temp    = 8'd0;
						nxt_ff      = 1'b0;
					end
					IO_CLR_MASK: nxt_mask = 4'd0;
					default: nxt_mask = req_item.data[3:0];
				endcase
			end
			default: begin
				if (disable_q || ((mask_q & bit_c) != 4'd0) || ((reqs & bit_c) == 4'd0)
					|| (md[1:0] != XT_VERIFY && md[1:0] != want)) begin
					res.status = ST_INVALID;
				end else if (md[1:0] != XT_VERIFY && req_item.mem_fault) begin
					res.status      = ST_MEM_FAULT;
					res.mem_valid   = 1'b1;
					res.mem_write   = to_mem;
					res.mem_address = {page_q[req_item.channel], ca};
					res.mem_data    = to_mem ? req_item.data : 8'd0;
				end else begin
					if (md[1:0] != XT_VERIFY) begin
						res.mem_valid   = 1'b1;
						res.mem_write   = to_mem;
						res.mem_address = {page_q[req_item.channel], ca};
						res.mem_data    = to_mem ? req_item.data : 8'd0;
					end
					nxt_temp      = req_item.data;
					res.read_data = to_mem ? 8'd0 : req_item.data;
					we_xfer       = 1'b1;
					term          = (cc == 16'd0);
					if (term) begin
						nxt_tc   = tc_q | bit_c;
						nxt_soft = soft_req_q & ~bit_c;
						if (md[2]) begin
							xf_addr = ba;
							xf_cnt  = bc;
						end
					end
					res.terminal = term;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumCh; i++) begin
				page_q[i]      <= 8'd0;
				base_addr_q[i] <= 16'd0;
				cur_addr_q[i]  <= 16'd0;
				base_cnt_q[i]  <= 16'd0;
				cur_cnt_q[i]   <= 16'd0;
				mode_q[i]      <= 4'd0;
			end
			disable_q   <= 1'b0;
			soft_req_q  <= 4'd0;
			tc_q        <= 4'd0;
			mask_q      <= 4'hf;
			temp_q      <= 8'd0;
			ff_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				page_q[cfg_index] <= cfg_data;
			end
			if (accept) begin
				disable_q  <= nxt_disable;
				soft_req_q <= nxt_soft;
				tc_q       <= nxt_tc;
				mask_q     <= nxt_mask;
				temp_q     <= nxt_temp;
				ff_q       <= nxt_ff;
				if (we_addr) begin
					base_addr_q[idx] <= new_ba;
					cur_addr_q[idx]  <= new_ca;
				end
				if (we_cnt) begin
					base_cnt_q[idx] <= new_bc;
					cur_cnt_q[idx]  <= new_cc;
				end
				if (we_xfer) begin
					cur_addr_q[idx] <= xf_addr;
					cur_cnt_q[idx]  <= xf_cnt;
				end
				if (we_mode) begin
					mode_q[req_item.data[1:0]] <= req_item.data[5:2];
				end
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// hold the result while stalled, load a fresh one on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_item_q <= res;
		end
	end

	`FCDMA_ASSERT_SAME(a_stall_only_when_full, req_stall, rsp_valid_q, "stall without held result")
	`FCDMA_ASSERT_SAME(a_fault_has_access, rsp_valid_q && rsp_item_q.status == ST_MEM_FAULT,
		rsp_item_q.mem_valid && !rsp_item_q.terminal && rsp_item_q.read_data == 8'd0,
		"memory fault result malformed")
	`FCDMA_ASSERT_SAME(a_refused_is_empty, rsp_valid_q && rsp_item_q.status == ST_INVALID,
		!rsp_item_q.mem_valid && !rsp_item_q.terminal && rsp_item_q.mem_address == 24'd0,
		"refused transfer carries data")
	`FCDMA_ASSERT_SAME(a_terminal_is_ok, rsp_valid_q && rsp_item_q.terminal,
		rsp_item_q.status == ST_OK, "terminal count on a failed beat")
	`FCDMA_ASSERT_NEXT(a_terminal_sets_tc, accept && res.terminal,
		tc_q[$past(req_item.channel)], "terminal count flag not set")

endmodule
